// ----- rtl/stt_pkg.sv -----
// Shared types, constants and codes for the software timer table.
`timescale 1ns / 1ps

package stt_pkg;

    // Number of timer slots in the table.
    localparam int TIMER_SLOTS = 8;
    localparam int SLOT_IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // Fixed field widths of the request and result.
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int COUNT_W  = 32;
    localparam int KIND_W   = 3;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_DEL  = 2'd2
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE       = 3'd0,
        KIND_RELOADED   = 3'd1,
        KIND_REMOVED    = 3'd2,
        KIND_ADDED      = 3'd3,
        KIND_ALREADY    = 3'd4,
        KIND_DELETED    = 3'd5,
        KIND_NOT_ACTIVE = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    // Write controls for the slot store.
    typedef struct packed {
        logic               rem_we;
        logic               rel_we;
        logic               act_set;
        logic               act_clr;
        slot_idx_t          addr;
        logic [COUNT_W-1:0] rem_data;
        logic [COUNT_W-1:0] rel_data;
    } store_wr_t;

    // Outcome of one pass of the shared decrement unit.
    typedef struct packed {
        logic               expired;
        logic               removed;
        logic [COUNT_W-1:0] next_rem;
    } dec_res_t;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot_id;
        logic              last;
    } result_t;

endpackage

// ----- rtl/software_timer_table.sv -----
// Top level of the software timer table: slot store, decrement unit, sequencer, output register.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  tuser mode; tdata slot, load_count, reload_count
//  m_*       out        m_tvalid/m_tready  tuser kind; tdata slot_id, tick_time; tlast last
//
// An add, delete or unused-mode request is accepted in the idle state, and the finish state
// places its result. A tick visits the TIMER_SLOTS slots in the scan state, one per
// cycle while the scan does not stall, through the single read address of the slot store and
// the shared decrementer, and the finish state places the last result.
// Each expiry after the first of a tick needs the output register to be free; while the
// downstream side holds m_tready low the scan waits on the current slot.
// Reset clears the sequencer, the output register, the active flags and the tick counter.
// The count memories are not cleared; a slot's counts are only used after an add has written it.

module software_timer_table
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
    input  logic [S_DATA_W-1:0] s_tdata,   // [2:0] slot, [34:3] load_count, [66:35] reload_count
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [KIND_W-1:0]   m_tuser,   // [2:0] kind
    output logic [M_DATA_W-1:0] m_tdata,   // [2:0] slot_id, [34:3] tick_time
    output logic                m_tlast
);

    // Unpacked request fields; the top bits of s_tdata are padding.
    logic [SLOT_W-1:0]      in_slot;
    logic [COUNT_W-1:0]     in_load;
    logic [COUNT_W-1:0]     in_reload;

    logic [COUNT_W-1:0]     rd_rem;
    logic [COUNT_W-1:0]     rd_rel;
    logic [TIMER_SLOTS-1:0] active;
    slot_idx_t              rd_addr;
    store_wr_t              wr;
    dec_res_t               dec;
    logic                   cur_act;
    logic                   out_free;
    logic                   emit_valid;
    result_t                emit;
    logic [COUNT_W-1:0]     tick_time;

    // Output register: one result waits here while the sequencer moves on.
    logic                   m_valid_reg;
    logic [KIND_W-1:0]      m_kind_reg;
    logic [SLOT_W-1:0]      m_slot_reg;
    logic [COUNT_W-1:0]     m_time_reg;
    logic                   m_last_reg;

    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_load   = s_tdata[SLOT_W +: COUNT_W];
    assign in_reload = s_tdata[SLOT_W + COUNT_W +: COUNT_W];

    stt_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_rem  (rd_rem),
        .rd_rel  (rd_rel),
        .active  (active)
    );

    stt_dec_unit u_dec (
        .slot_act (cur_act),
        .rem      (rd_rem),
        .rel      (rd_rel),
        .res      (dec)
    );

    stt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_slot    (in_slot),
        .in_load    (in_load),
        .in_reload  (in_reload),
        .active     (active),
        .dec        (dec),
        .cur_act    (cur_act),
        .rd_addr    (rd_addr),
        .wr         (wr),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit       (emit),
        .tick_time  (tick_time)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            m_kind_reg <= emit.kind;
            m_slot_reg <= emit.slot_id;
            m_time_reg <= tick_time;
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {(M_DATA_W - SLOT_W - COUNT_W)'(0), m_time_reg, m_slot_reg};
    assign m_tlast  = m_last_reg;

    // The sequencer only hands over a result when the output register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> out_free)
        else $error("result emitted while output register is occupied");

    // An accepted tick request advances the tick counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_TICK)) |=>
            (tick_time == $past(tick_time) + 32'd1))
        else $error("tick counter did not advance on a tick request");

    // A no-expiry result always names slot zero and closes its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_NONE)) |-> ((m_tdata[SLOT_W-1:0] == '0) && m_tlast))
        else $error("no-expiry result with nonzero slot or without last");

    // No new request is taken while a tick scan is still walking the slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == MODE_TICK)) |=> !s_tready)
        else $error("request accepted during a slot scan");

endmodule

// ----- rtl/stt_slot_store.sv -----
// Slot store: remaining and reload count memories plus the active flags.
`timescale 1ns / 1ps

module stt_slot_store
    import stt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  store_wr_t              wr,
    input  slot_idx_t              rd_addr,
    output logic [COUNT_W-1:0]     rd_rem,
    output logic [COUNT_W-1:0]     rd_rel,
    output logic [TIMER_SLOTS-1:0] active
);

    logic [COUNT_W-1:0]     rem_mem [TIMER_SLOTS];
    logic [COUNT_W-1:0]     rel_mem [TIMER_SLOTS];
    logic [COUNT_W-1:0]     rd_rem_reg;
    logic [COUNT_W-1:0]     rd_rel_reg;
    logic [TIMER_SLOTS-1:0] active_reg;

    // Both memories have one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr.rem_we)
        begin
            rem_mem[wr.addr] <= wr.rem_data;
        end
        if (wr.rel_we)
        begin
            rel_mem[wr.addr] <= wr.rel_data;
        end
        rd_rem_reg <= rem_mem[rd_addr];
        rd_rel_reg <= rel_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr.act_set)
        begin
            active_reg[wr.addr] <= 1'b1;
        end
        else if (wr.act_clr)
        begin
            active_reg[wr.addr] <= 1'b0;
        end
    end

    assign rd_rem = rd_rem_reg;
    assign rd_rel = rd_rel_reg;
    assign active = active_reg;

endmodule

// ----- rtl/stt_dec_unit.sv -----
// Shared decrement unit: counts one slot down and decides expiry and reload.
`timescale 1ns / 1ps

module stt_dec_unit
    import stt_pkg::*;
(
    input  logic               slot_act,
    input  logic [COUNT_W-1:0] rem,
    input  logic [COUNT_W-1:0] rel,
    output dec_res_t           res
);

    logic [COUNT_W-1:0] dec;
    logic               hit_zero;
    logic               has_reload;

    assign dec        = rem - 32'd1;
    assign hit_zero   = (dec == '0);
    assign has_reload = (rel != '0);

    always_comb
    begin
        res.expired  = slot_act && hit_zero;
        res.removed  = slot_act && hit_zero && !has_reload;
        res.next_rem = (hit_zero && has_reload) ? rel : dec;
    end

endmodule

// ----- rtl/stt_seq.sv -----
// Sequencer: takes requests, walks the slots through the decrement unit, emits results.
`timescale 1ns / 1ps

module stt_seq
    import stt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      in_mode,
    input  logic [SLOT_W-1:0]      in_slot,
    input  logic [COUNT_W-1:0]     in_load,
    input  logic [COUNT_W-1:0]     in_reload,
    input  logic [TIMER_SLOTS-1:0] active,
    input  dec_res_t               dec,
    output logic                   cur_act,
    output slot_idx_t              rd_addr,
    output store_wr_t              wr,
    input  logic                   out_free,
    output logic                   emit_valid,
    output result_t                emit,
    output logic [COUNT_W-1:0]     tick_time
);

    state_t             state_reg;
    state_t             state_next;
    slot_idx_t          idx_reg;
    logic [COUNT_W-1:0] tick_reg;
    logic               held_valid_reg;
    kind_t              held_kind_reg;
    logic [SLOT_W-1:0]  held_id_reg;

    slot_idx_t          sidx;
    logic               slot_ok;
    logic               req_act;
    logic               last_slot;
    logic               stall;
    logic               advance;

    assign sidx      = SLOT_IDX_W'(in_slot);
    assign slot_ok   = (32'(in_slot) < TIMER_SLOTS);
    assign req_act   = slot_ok && active[sidx];
    assign cur_act   = active[idx_reg];
    assign last_slot = (idx_reg == SLOT_IDX_W'(TIMER_SLOTS - 1));
    // A new expiry pushes the held one out, which needs a free output register.
    assign stall     = dec.expired && held_valid_reg && !out_free;
    assign advance   = !stall;
    assign tick_time = tick_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_mode == MODE_TICK) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (advance && last_slot)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        rd_addr      = idx_reg;
        wr           = '0;
        wr.addr      = idx_reg;
        emit_valid   = 1'b0;
        emit.kind    = held_kind_reg;
        emit.slot_id = held_id_reg;
        emit.last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = '0;
                wr.addr  = sidx;
                wr.rem_data = in_load;
                wr.rel_data = in_reload;
                if (in_valid && (in_mode == MODE_ADD) && slot_ok && !req_act)
                begin
                    wr.rem_we  = 1'b1;
                    wr.rel_we  = 1'b1;
                    wr.act_set = 1'b1;
                end
                if (in_valid && (in_mode == MODE_DEL) && req_act)
                begin
                    wr.act_clr = 1'b1;
                end
            end
            ST_SCAN:
            begin
                wr.rem_data = dec.next_rem;
                if (advance)
                begin
                    wr.rem_we  = cur_act;
                    wr.act_clr = dec.removed;
                    rd_addr    = last_slot ? idx_reg : idx_reg + 1'b1;
                    emit_valid = dec.expired && held_valid_reg;
                end
            end
            ST_FIN:
            begin
                emit_valid   = out_free;
                emit.kind    = held_valid_reg ? held_kind_reg : KIND_NONE;
                emit.slot_id = held_valid_reg ? held_id_reg : '0;
                emit.last    = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            tick_reg       <= '0;
            held_valid_reg <= 1'b0;
            held_kind_reg  <= KIND_NONE;
            held_id_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && in_valid)
            begin
                idx_reg     <= '0;
                held_id_reg <= in_slot;
                case (in_mode)
                    MODE_TICK:
                    begin
                        tick_reg       <= tick_reg + 32'd1;
                        held_valid_reg <= 1'b0;
                    end
                    MODE_ADD:
                    begin
                        held_valid_reg <= 1'b1;
                        if (!slot_ok)
                        begin
                            held_kind_reg <= KIND_NOT_ACTIVE;
                        end
                        else if (req_act)
                        begin
                            held_kind_reg <= KIND_ALREADY;
                        end
                        else
                        begin
                            held_kind_reg <= KIND_ADDED;
                        end
                    end
                    MODE_DEL:
                    begin
                        held_valid_reg <= 1'b1;
                        held_kind_reg  <= req_act ? KIND_DELETED : KIND_NOT_ACTIVE;
                    end
                    default:
                    begin
                        held_valid_reg <= 1'b0;
                    end
                endcase
            end
            else if ((state_reg == ST_SCAN) && advance)
            begin
                if (!last_slot)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (dec.expired)
                begin
                    held_valid_reg <= 1'b1;
                    held_kind_reg  <= dec.removed ? KIND_REMOVED : KIND_RELOADED;
                    held_id_reg    <= SLOT_W'(idx_reg);
                end
            end
        end
    end

endmodule

// ----- dv/software_timer_table_tb.sv -----
// Self-checking testbench for the software timer table with a scoreboard and paced stream drivers.
`timescale 1ns / 1ps

module software_timer_table_tb;
    import stt_pkg::*;

    // Mode value that the block leaves undecoded; it must answer with a plain
    // no-expiry result and leave the tick counter alone.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 260;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 30;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int PAD_W           = S_DATA_W - 2 * COUNT_W - SLOT_W;

    // One expected result as the output channel presents it.
    typedef struct {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot_id;
        logic [COUNT_W-1:0] tick_time;
        logic               last;
    } timer_result_t;

    // The scoreboard keeps its own copy of the slot table. Every accepted
    // request is run through it at once, and the results it would cause are
    // queued in order until the output channel delivers them.
    class timer_table_scoreboard;
        logic [COUNT_W-1:0] remaining [TIMER_SLOTS];
        logic [COUNT_W-1:0] reload_val[TIMER_SLOTS];
        bit                 active    [TIMER_SLOTS];
        logic [COUNT_W-1:0] tick_count;
        timer_result_t      expected_q[$];
        int                 mismatches;

        function new();
            foreach (active[i]) active[i] = 1'b0;
            tick_count = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        function void push_result(kind_t kind, logic [SLOT_W-1:0] id, logic fin);
            timer_result_t r;
            r.kind      = kind;
            r.slot_id   = id;
            r.tick_time = tick_count;
            r.last      = fin;
            expected_q.push_back(r);
        endfunction

        // Applies one accepted request to the local table.
        function void note_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                                   logic [COUNT_W-1:0] load, logic [COUNT_W-1:0] reload);
            kind_t hit_kind[$];
            int    hit_slot[$];
            if (mode == MODE_TICK) begin
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < TIMER_SLOTS; i++) begin
                    if (active[i]) begin
                        remaining[i] = remaining[i] - 1'b1;
                        if (remaining[i] == '0) begin
                            if (reload_val[i] != '0) begin
                                remaining[i] = reload_val[i];
                                hit_kind.push_back(KIND_RELOADED);
                            end
                            else begin
                                active[i] = 1'b0;
                                hit_kind.push_back(KIND_REMOVED);
                            end
                            hit_slot.push_back(i);
                        end
                    end
                end
                // Expiries come out in slot order; only the final one is marked last.
                if (hit_kind.size() == 0)
                    push_result(KIND_NONE, '0, 1'b1);
                else
                    foreach (hit_kind[j])
                        push_result(hit_kind[j], hit_slot[j][SLOT_W-1:0],
                                    j == hit_kind.size() - 1);
            end
            else if (mode == MODE_ADD) begin
                if (int'(slot) >= TIMER_SLOTS)
                    push_result(KIND_NOT_ACTIVE, slot, 1'b1);
                else if (active[slot])
                    push_result(KIND_ALREADY, slot, 1'b1);
                else begin
                    remaining[slot]  = load;
                    reload_val[slot] = reload;
                    active[slot]     = 1'b1;
                    push_result(KIND_ADDED, slot, 1'b1);
                end
            end
            else if (mode == MODE_DEL) begin
                if (int'(slot) < TIMER_SLOTS && active[slot]) begin
                    active[slot] = 1'b0;
                    push_result(KIND_DELETED, slot, 1'b1);
                end
                else
                    push_result(KIND_NOT_ACTIVE, slot, 1'b1);
            end
            else
                push_result(KIND_NONE, '0, 1'b1);
        endfunction

        // Compares one delivered result with the oldest expectation.
        task check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] id,
                          logic [COUNT_W-1:0] tick_time, logic fin);
            timer_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing outstanding, kind", kind, 0);
            end
            else begin
                want = expected_q.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (id !== want.slot_id)
                    report_mismatch("slot_id", id, want.slot_id);
                if (tick_time !== want.tick_time)
                    report_mismatch("tick_time", tick_time, want.tick_time);
                if (fin !== want.last)
                    report_mismatch("last", fin, want.last);
            end
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [MODE_W-1:0]   s_tuser;   // [1:0] mode
    logic [S_DATA_W-1:0] s_tdata;   // [2:0] slot, [34:3] load_count, [66:35] reload_count
    logic                m_tvalid;
    logic                m_tready;
    logic [KIND_W-1:0]   m_tuser;   // [2:0] kind
    logic [M_DATA_W-1:0] m_tdata;   // [2:0] slot_id, [34:3] tick_time
    logic                m_tlast;

    timer_table_scoreboard sb = new();

    // Sender pacing state: a burst counts down requests, a gap follows it.
    int burst_left = 0;
    // Raised by the stimulus once the random part starts; the receiver answers
    // with a single long hold-off of its own.
    bit hold_armed = 1'b0;
    int cycle_count = 0;

    software_timer_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Presents one request and waits for the handshake. Between bursts the
    // valid line drops for a random gap, so a new
    // request never lowers and raises valid within the same time step.
    task send_request(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                      logic [COUNT_W-1:0] load, logic [COUNT_W-1:0] reload);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{PAD_W{1'b0}}, reload, load, slot};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(mode, slot, load, reload);
    endtask

    // Stops offering requests until every outstanding result has arrived.
    task drain_results();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Draws one random request. The largest share of traffic is ticks against a table filled
    // with short counts so that expiries and reloads happen often; a small
    // share uses full-range counts, and a few requests use the unused mode.
    task random_request(output bit counted);
        int                 pick;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] load;
        logic [COUNT_W-1:0] reload;
        pick    = $urandom_range(0, 99);
        slot    = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
        load    = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 6);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: reload = '0;
            17, 18, 19:             reload = $urandom();
            default:                reload = $urandom_range(1, 8);
        endcase
        counted = 1'b1;
        if (pick < 45)
            send_request(MODE_TICK, slot, load, reload);
        else if (pick < 75)
            send_request(MODE_ADD, slot, load, reload);
        else if (pick < 93)
            send_request(MODE_DEL, slot, load, reload);
        else begin
            send_request(MODE_UNUSED, slot, load, reload);
            counted = 1'b0;
        end
    endtask

    // Receiver: it cycles through always ready, random stalls and runs of
    // stalls, and once the random part begins it holds off for a long
    // stretch so that the block backs up and stops taking requests.
    initial
    begin
        int  own_cycles;
        int  hold_left;
        bit  hold_done;
        int  run_left;
        bit  run_level;
        own_cycles = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        run_left   = 0;
        run_level  = 1'b1;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            own_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else begin
                case ((own_cycles / 96) % 3)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 2) != 0);
                    default: begin
                        if (run_left == 0) begin
                            run_left  = $urandom_range(1, 8);
                            run_level = ~run_level;
                        end
                        run_left--;
                        m_tready <= run_level;
                    end
                endcase
            end
        end
    end

    // Every delivered result is checked against the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[SLOT_W-1:0],
                            m_tdata[SLOT_W +: COUNT_W], m_tlast);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int accepted;
        bit counted;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A tick on an empty table, then delete and add on
        // idle and active slots, a one-shot expiry, repeated reloads, the
        // count extremes (a zero load wraps to the full count), the unused
        // mode, and finally all slots expiring on the same tick.
        send_request(MODE_TICK, '0, '0, '0);
        send_request(MODE_DEL, 3'd3, '0, '0);
        send_request(MODE_ADD, 3'd0, 32'd1, 32'd0);
        send_request(MODE_ADD, 3'd0, 32'd9, 32'd9);
        send_request(MODE_ADD, 3'd7, 32'd2, 32'd1);
        send_request(MODE_TICK, '0, '0, '0);
        send_request(MODE_TICK, '0, '0, '0);
        send_request(MODE_TICK, '0, '0, '0);
        send_request(MODE_DEL, 3'd7, '0, '0);
        send_request(MODE_ADD, 3'd5, 32'd0, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_DEL, 3'd5, '0, '0);
        send_request(MODE_DEL, 3'd6, '0, '0);
        for (int i = 0; i < TIMER_SLOTS; i++)
            send_request(MODE_ADD, i[SLOT_W-1:0], 32'd1, (i % 2 == 1) ? 32'd2 : 32'd0);
        send_request(MODE_TICK, '0, '0, '0);

        // Let the directed results drain before the long hold-off starts.
        drain_results();
        hold_armed = 1'b1;

        accepted = 0;
        while (accepted < RANDOM_REQUESTS) begin
            random_request(counted);
            if (counted)
                accepted++;
            if ($urandom_range(0, 39) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results still outstanding at the end", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
